>>> hw/rtl/tdcc_pkg.sv
// ----------------------------------------------------------------------------
// tdcc_pkg: shared types and constants of the calendar clock
// Function codes, controller states, command and status words between the
// controller and the datapath, and the calendar constants.
// ----------------------------------------------------------------------------
package tdcc_pkg;

  localparam int unsigned TICK_W = 48;
  localparam int unsigned SEC_W  = 40;
  localparam int unsigned NS_W   = 30;

  localparam logic [NS_W-1:0] NS_PER_SEC        = 30'd1000000000;
  localparam logic [NS_W-1:0] NS_MAX            = 30'd999999999;
  localparam logic [NS_W-1:0] NS_PER_TICK_RESET = 30'd10000000;

  // floor(y / 400) as (y * YEAR_RECIP) >> YEAR_RECIP_SHIFT, exact for 14-bit y
  localparam logic [12:0] YEAR_RECIP       = 13'd5243;
  localparam int unsigned YEAR_RECIP_SHIFT = 21;
  localparam logic [8:0]  YEARS_PER_ERA    = 9'd400;

  localparam logic signed [24:0] DAYS_PER_ERA    = 25'sd146097;
  localparam logic signed [24:0] DAYS_PER_YEAR   = 25'sd365;
  localparam logic signed [24:0] EPOCH_DAY_SHIFT = 25'sd719468;
  localparam logic signed [41:0] SEC_PER_DAY     = 42'sd86400;

  // APB register map
  localparam logic REG_NS_PER_TICK = 1'b0;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_DATE    = 2'd1,
    FUNC_SECONDS = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CIV_YOE,
    ST_CIV_DAYS,
    ST_CIV_SECS,
    ST_PUBLISH
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic apply;
    logic civ_yoe;
    logic civ_days;
    logic civ_secs;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_date;
  } dp_status_t;

  // Days from March 1 to the first of the month, year starting in March
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] off;
    unique case (month)
      4'd0:    off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd13:   off = 9'd306;
      4'd14:   off = 9'd337;
      default: off = 9'd367;
    endcase
    return off;
  endfunction

endpackage

>>> hw/rtl/tdcc_ctrl.sv
// ----------------------------------------------------------------------------
// tdcc_ctrl: sequencer of the calendar clock
// Accepts one word at a time, steps the datapath through the date stages for
// set-date words and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module tdcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tdcc_pkg::dp_status_t status_i,
  output tdcc_pkg::dp_cmd_t    cmd_o
);

  tdcc_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdcc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tdcc_pkg::ST_APPLY;
      end
      tdcc_pkg::ST_APPLY: begin
        state_d = status_i.is_date ? tdcc_pkg::ST_CIV_YOE : tdcc_pkg::ST_PUBLISH;
      end
      tdcc_pkg::ST_CIV_YOE:  state_d = tdcc_pkg::ST_CIV_DAYS;
      tdcc_pkg::ST_CIV_DAYS: state_d = tdcc_pkg::ST_CIV_SECS;
      tdcc_pkg::ST_CIV_SECS: state_d = tdcc_pkg::ST_PUBLISH;
      tdcc_pkg::ST_PUBLISH: begin
        if (out_free) state_d = tdcc_pkg::ST_IDLE;
      end
      default: state_d = tdcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tdcc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tdcc_pkg::ST_APPLY:    cmd_o.apply    = 1'b1;
      tdcc_pkg::ST_CIV_YOE:  cmd_o.civ_yoe  = 1'b1;
      tdcc_pkg::ST_CIV_DAYS: cmd_o.civ_days = 1'b1;
      tdcc_pkg::ST_CIV_SECS: cmd_o.civ_secs = 1'b1;
      tdcc_pkg::ST_PUBLISH:  cmd_o.publish  = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.publish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a waiting word");

  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == tdcc_pkg::ST_APPLY)
    else $error("accepted word not applied");

  a_rise_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.publish))
    else $error("output valid without publish");

  a_date_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tdcc_pkg::ST_CIV_SECS |-> $past(state_q, 2) == tdcc_pkg::ST_CIV_YOE)
    else $error("date stages skipped");

endmodule

>>> hw/rtl/tdcc_datapath.sv
// ----------------------------------------------------------------------------
// tdcc_datapath: counters and date arithmetic of the calendar clock
// Holds the tick count, wall time and uptime, the days-from-civil stages and
// the output register.
// ----------------------------------------------------------------------------
module tdcc_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tdcc_pkg::dp_cmd_t          cmd_i,
  output tdcc_pkg::dp_status_t       status_o,
  input  logic [1:0]                 func_i,
  input  logic [13:0]                year_i,
  input  logic [3:0]                 month_i,
  input  logic [4:0]                 day_i,
  input  logic [4:0]                 hour_i,
  input  logic [5:0]                 minute_i,
  input  logic [5:0]                 second_i,
  input  logic signed [39:0]         set_seconds_i,
  input  logic [29:0]                set_nanoseconds_i,
  input  logic [29:0]                ns_per_tick_i,
  output logic [47:0]                tick_total_o,
  output logic signed [39:0]         now_seconds_o,
  output logic [29:0]                now_nanoseconds_o,
  output logic signed [39:0]         uptime_seconds_o,
  output logic [29:0]                uptime_nanoseconds_o
);

  // captured word
  tdcc_pkg::func_e    func_q;
  logic [13:0]        year_q;
  logic [3:0]         month_q;
  logic [4:0]         day_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic [5:0]         second_q;
  logic [39:0]        set_sec_q;
  logic [29:0]        set_ns_q;

  // clock state
  logic [47:0] tick_q, tick_d;
  logic [39:0] wall_sec_q, wall_sec_d;
  logic [29:0] wall_ns_q, wall_ns_d;
  logic [39:0] boot_sec_q, boot_sec_d;
  logic [29:0] boot_ns_q, boot_ns_d;

  // date stages
  logic               civ_neg_q;
  logic [13:0]        civ_ypos;
  logic [26:0]        civ_prod;
  logic [5:0]         civ_q_q;
  logic [13:0]        civ_y_q;
  logic signed [9:0]  doy_q, doy_d;
  logic [16:0]        tod_q, tod_d;
  logic [14:0]        rem;
  logic signed [6:0]  era_q, era_d;
  logic [8:0]         yoe_q, yoe_d;
  logic [1:0]         yoe_c100;
  logic signed [24:0] yoe_s, doe_s, era_days_s;
  logic signed [24:0] days_q, days_d;
  logic signed [41:0] civ_secs;

  // output register
  logic [47:0] out_tick_q;
  logic [39:0] out_wall_sec_q, out_boot_sec_q;
  logic [29:0] out_wall_ns_q, out_boot_ns_q;

  logic [29:0] step;
  logic [29:0] set_ns_clamp;
  logic [30:0] wall_sum, boot_sum;

  assign status_o.is_date = (func_q == tdcc_pkg::FUNC_DATE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= tdcc_pkg::func_e'(func_i);
      year_q    <= year_i;
      month_q   <= month_i;
      day_q     <= day_i;
      hour_q    <= hour_i;
      minute_q  <= minute_i;
      second_q  <= second_i;
      set_sec_q <= set_seconds_i;
      set_ns_q  <= set_nanoseconds_i;
    end
  end

  // stage A: shifted year, era estimate, day of year, time of day
  assign civ_ypos = (month_q <= 4'd2 && year_q != 14'd0) ? year_q - 14'd1 : year_q;
  assign civ_prod = 27'(civ_ypos) * 27'(tdcc_pkg::YEAR_RECIP);
  assign doy_d    = $signed(10'(tdcc_pkg::month_offset(month_q))) + $signed(10'(day_q))
                    - 10'sd1;
  assign tod_d    = 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);

  // stage B: era and year of era
  assign rem = 15'(civ_y_q) - 15'(civ_q_q) * 15'(tdcc_pkg::YEARS_PER_ERA);
  always_comb begin
    priority if (civ_neg_q) begin
      era_d = -7'sd1;
      yoe_d = 9'd399;
    end else if (rem >= 15'(tdcc_pkg::YEARS_PER_ERA)) begin
      era_d = $signed(7'(civ_q_q) + 7'd1);
      yoe_d = 9'(rem - 15'(tdcc_pkg::YEARS_PER_ERA));
    end else begin
      era_d = $signed(7'(civ_q_q));
      yoe_d = 9'(rem);
    end
  end

  // stage C: day number
  always_comb begin
    priority if (yoe_q >= 9'd300) yoe_c100 = 2'd3;
    else if (yoe_q >= 9'd200)     yoe_c100 = 2'd2;
    else if (yoe_q >= 9'd100)     yoe_c100 = 2'd1;
    else                          yoe_c100 = 2'd0;
  end
  assign yoe_s      = $signed(25'(yoe_q));
  assign doe_s      = yoe_s * tdcc_pkg::DAYS_PER_YEAR + (yoe_s >>> 2)
                      - $signed(25'(yoe_c100)) + 25'(doy_q);
  assign era_days_s = 25'(era_q) * tdcc_pkg::DAYS_PER_ERA;
  assign days_d     = era_days_s + doe_s - tdcc_pkg::EPOCH_DAY_SHIFT;

  // stage D: seconds
  assign civ_secs = 42'(days_q) * tdcc_pkg::SEC_PER_DAY + $signed(42'(tod_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      civ_neg_q <= (month_q <= 4'd2 && year_q == 14'd0);
      civ_y_q   <= civ_ypos;
      civ_q_q   <= civ_prod[26:tdcc_pkg::YEAR_RECIP_SHIFT];
      doy_q     <= doy_d;
      tod_q     <= tod_d;
    end
    if (cmd_i.civ_yoe) begin
      era_q <= era_d;
      yoe_q <= yoe_d;
    end
    if (cmd_i.civ_days) begin
      days_q <= days_d;
    end
  end

  // counters
  assign step         = (ns_per_tick_i > tdcc_pkg::NS_MAX) ? tdcc_pkg::NS_MAX : ns_per_tick_i;
  assign set_ns_clamp = (set_ns_q > tdcc_pkg::NS_MAX) ? tdcc_pkg::NS_MAX : set_ns_q;
  assign wall_sum     = 31'(wall_ns_q) + 31'(step);
  assign boot_sum     = 31'(boot_ns_q) + 31'(step);

  always_comb begin
    tick_d     = tick_q;
    wall_sec_d = wall_sec_q;
    wall_ns_d  = wall_ns_q;
    boot_sec_d = boot_sec_q;
    boot_ns_d  = boot_ns_q;
    if (cmd_i.apply) begin
      unique case (func_q)
        tdcc_pkg::FUNC_TICK: begin
          tick_d = tick_q + 48'd1;
          if (wall_sum >= 31'(tdcc_pkg::NS_PER_SEC)) begin
            wall_ns_d  = 30'(wall_sum - 31'(tdcc_pkg::NS_PER_SEC));
            wall_sec_d = wall_sec_q + 40'd1;
          end else begin
            wall_ns_d = 30'(wall_sum);
          end
          if (boot_sum >= 31'(tdcc_pkg::NS_PER_SEC)) begin
            boot_ns_d  = 30'(boot_sum - 31'(tdcc_pkg::NS_PER_SEC));
            boot_sec_d = boot_sec_q + 40'd1;
          end else begin
            boot_ns_d = 30'(boot_sum);
          end
        end
        tdcc_pkg::FUNC_SECONDS: begin
          wall_sec_d = set_sec_q;
          wall_ns_d  = set_ns_clamp;
        end
        tdcc_pkg::FUNC_DATE: ;
        tdcc_pkg::FUNC_READ: ;
        default: ;
      endcase
    end else if (cmd_i.civ_secs) begin
      wall_sec_d = civ_secs[39:0];
      wall_ns_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      wall_sec_q <= '0;
      wall_ns_q  <= '0;
      boot_sec_q <= '0;
      boot_ns_q  <= '0;
    end else begin
      tick_q     <= tick_d;
      wall_sec_q <= wall_sec_d;
      wall_ns_q  <= wall_ns_d;
      boot_sec_q <= boot_sec_d;
      boot_ns_q  <= boot_ns_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_tick_q     <= tick_q;
      out_wall_sec_q <= wall_sec_q;
      out_wall_ns_q  <= wall_ns_q;
      out_boot_sec_q <= boot_sec_q;
      out_boot_ns_q  <= boot_ns_q;
    end
  end

  assign tick_total_o         = out_tick_q;
  assign now_seconds_o        = $signed(out_wall_sec_q);
  assign now_nanoseconds_o    = out_wall_ns_q;
  assign uptime_seconds_o     = $signed(out_boot_sec_q);
  assign uptime_nanoseconds_o = out_boot_ns_q;

endmodule

>>> hw/rtl/tick_driven_calendar_clock.sv
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock: tick-driven real-time clock with date load
// Tick, set-seconds and read words pass through the apply and publish steps;
// set-date words also go through the year-of-era, day and seconds stages.
// The sequencer holds one word at a time and takes no new word until the
// result is published, which waits for the output register to be free.
// Reset: all counters clear to zero, ns_per_tick returns to 10000000.
// ----------------------------------------------------------------------------
module tick_driven_calendar_clock (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [13:0]         year_i,
  input  logic [3:0]          month_i,
  input  logic [4:0]          day_i,
  input  logic [4:0]          hour_i,
  input  logic [5:0]          minute_i,
  input  logic [5:0]          second_i,
  input  logic signed [39:0]  set_seconds_i,
  input  logic [29:0]         set_nanoseconds_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [47:0]         tick_total_o,
  output logic signed [39:0]  now_seconds_o,
  output logic [29:0]         now_nanoseconds_o,
  output logic signed [39:0]  uptime_seconds_o,
  output logic [29:0]         uptime_nanoseconds_o,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tdcc_pkg::dp_cmd_t    cmd;
  tdcc_pkg::dp_status_t status;

  logic [29:0] ns_per_tick_q, ns_per_tick_d;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tdcc_pkg::REG_NS_PER_TICK);

  assign ns_per_tick_d = (psel && penable && pwrite && reg_sel) ? pwdata[29:0]
                                                                 : ns_per_tick_q;
  assign prdata        = reg_sel ? {2'b00, ns_per_tick_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_per_tick_q <= tdcc_pkg::NS_PER_TICK_RESET;
    end else begin
      ns_per_tick_q <= ns_per_tick_d;
    end
  end

  tdcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdcc_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .func_i               (func_i),
    .year_i               (year_i),
    .month_i              (month_i),
    .day_i                (day_i),
    .hour_i               (hour_i),
    .minute_i             (minute_i),
    .second_i             (second_i),
    .set_seconds_i        (set_seconds_i),
    .set_nanoseconds_i    (set_nanoseconds_i),
    .ns_per_tick_i        (ns_per_tick_q),
    .tick_total_o         (tick_total_o),
    .now_seconds_o        (now_seconds_o),
    .now_nanoseconds_o    (now_nanoseconds_o),
    .uptime_seconds_o     (uptime_seconds_o),
    .uptime_nanoseconds_o (uptime_nanoseconds_o)
  );

endmodule

>>> dv/tick_driven_calendar_clock_test.sv
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock_test: self-checking bench of the calendar clock
// Drives tick, date-load, seconds-load and read words with random gaps and
// result stalls, rewrites the tick step over APB between phases, and checks
// every result word against a cycle-free model of the counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_driven_calendar_clock_test;

  typedef struct {
    tdcc_pkg::func_e    func;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic signed [39:0] set_sec;
    logic [29:0]        set_ns;
  } clock_word_t;

  typedef struct {
    logic [tdcc_pkg::TICK_W-1:0] ticks;
    logic [tdcc_pkg::SEC_W-1:0]  now_s;
    logic [tdcc_pkg::NS_W-1:0]   now_ns;
    logic [tdcc_pkg::SEC_W-1:0]  up_s;
    logic [tdcc_pkg::NS_W-1:0]   up_ns;
  } clock_reading_t;

  localparam logic [2:0]  STEP_ADDR     = 3'(4 * tdcc_pkg::REG_NS_PER_TICK);
  localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
  localparam logic [39:0] SEC_MAX       = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] SEC_MIN       = 40'h80_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func = '0;
  logic [13:0]        year = '0;
  logic [3:0]         month = '0;
  logic [4:0]         day = '0;
  logic [4:0]         hour = '0;
  logic [5:0]         minute = '0;
  logic [5:0]         second = '0;
  logic signed [39:0] set_sec = '0;
  logic [29:0]        set_ns = '0;

  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [47:0]        tick_total_o;
  logic signed [39:0] now_seconds_o;
  logic [29:0]        now_nanoseconds_o;
  logic signed [39:0] uptime_seconds_o;
  logic [29:0]        uptime_nanoseconds_o;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model state
  logic [tdcc_pkg::NS_W-1:0]   step_reg = tdcc_pkg::NS_PER_TICK_RESET;
  logic [tdcc_pkg::TICK_W-1:0] tick_count = '0;
  logic [tdcc_pkg::SEC_W-1:0]  wall_s = '0;
  logic [tdcc_pkg::NS_W-1:0]   wall_ns = '0;
  logic [tdcc_pkg::SEC_W-1:0]  up_s = '0;
  logic [tdcc_pkg::NS_W-1:0]   up_ns = '0;

  clock_reading_t expected_readings[$];
  bit idle_on = 1'b1;
  int stall_left = 0;
  int mismatches = 0;
  int readings_seen = 0;
  int step_settings = 0;
  int word_count[4] = '{0, 0, 0, 0};

  tick_driven_calendar_clock u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .func_i              (func),
    .year_i              (year),
    .month_i             (month),
    .day_i               (day),
    .hour_i              (hour),
    .minute_i            (minute),
    .second_i            (second),
    .set_seconds_i       (set_sec),
    .set_nanoseconds_i   (set_ns),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .tick_total_o        (tick_total_o),
    .now_seconds_o       (now_seconds_o),
    .now_nanoseconds_o   (now_nanoseconds_o),
    .uptime_seconds_o    (uptime_seconds_o),
    .uptime_nanoseconds_o(uptime_nanoseconds_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  // returns {carry, nanoseconds}
  function automatic logic [tdcc_pkg::NS_W:0] add_ns(input logic [tdcc_pkg::NS_W-1:0] ns,
                                                     input logic [tdcc_pkg::NS_W-1:0] step);
    logic [tdcc_pkg::NS_W:0] sum;
    sum = {1'b0, ns} + {1'b0, step};
    if (sum >= {1'b0, tdcc_pkg::NS_PER_SEC}) begin
      sum = sum - {1'b0, tdcc_pkg::NS_PER_SEC};
      return {1'b1, sum[tdcc_pkg::NS_W-1:0]};
    end
    return {1'b0, sum[tdcc_pkg::NS_W-1:0]};
  endfunction

  function automatic logic [tdcc_pkg::SEC_W-1:0] date_to_unix(input clock_word_t w);
    longint y, m, era, yoe, doy, doe, days, secs;
    y = longint'(w.year);
    m = longint'(w.month);
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + longint'(w.day) - 1;
    doe = yoe * longint'(tdcc_pkg::DAYS_PER_YEAR) + yoe / 4 - yoe / 100 + doy;
    days = era * longint'(tdcc_pkg::DAYS_PER_ERA) + doe
           - longint'(tdcc_pkg::EPOCH_DAY_SHIFT);
    secs = days * 86400 + longint'(w.hour) * 3600 + longint'(w.minute) * 60
           + longint'(w.second);
    return secs[tdcc_pkg::SEC_W-1:0];
  endfunction

  function automatic clock_reading_t apply_word(input clock_word_t w);
    logic [tdcc_pkg::NS_W-1:0] step;
    logic [tdcc_pkg::NS_W:0]   nxt;
    clock_reading_t            r;
    case (w.func)
      tdcc_pkg::FUNC_TICK: begin
        step = (step_reg > tdcc_pkg::NS_MAX) ? tdcc_pkg::NS_MAX : step_reg;
        tick_count = tick_count + 48'd1;
        nxt = add_ns(up_ns, step);
        up_ns = nxt[tdcc_pkg::NS_W-1:0];
        up_s = up_s + 40'(nxt[tdcc_pkg::NS_W]);
        nxt = add_ns(wall_ns, step);
        wall_ns = nxt[tdcc_pkg::NS_W-1:0];
        wall_s = wall_s + 40'(nxt[tdcc_pkg::NS_W]);
      end
      tdcc_pkg::FUNC_DATE: begin
        wall_s = date_to_unix(w);
        wall_ns = '0;
      end
      tdcc_pkg::FUNC_SECONDS: begin
        wall_s = w.set_sec;
        wall_ns = (w.set_ns > tdcc_pkg::NS_MAX) ? tdcc_pkg::NS_MAX : w.set_ns;
      end
      tdcc_pkg::FUNC_READ: ;
      default: ;
    endcase
    r.ticks = tick_count;
    r.now_s = wall_s;
    r.now_ns = wall_ns;
    r.up_s = up_s;
    r.up_ns = up_ns;
    return r;
  endfunction

  function automatic clock_word_t plain_word(input tdcc_pkg::func_e f);
    clock_word_t w;
    w = '{func: f, year: '0, month: '0, day: '0, hour: '0, minute: '0, second: '0,
          set_sec: '0, set_ns: '0};
    return w;
  endfunction

  function automatic clock_word_t date_word(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s);
    clock_word_t w;
    w = plain_word(tdcc_pkg::FUNC_DATE);
    w.year = 14'(y);
    w.month = 4'(mo);
    w.day = 5'(d);
    w.hour = 5'(h);
    w.minute = 6'(mi);
    w.second = 6'(s);
    return w;
  endfunction

  function automatic clock_word_t seconds_word(input logic [39:0] s,
                                               input logic [29:0] ns);
    clock_word_t w;
    w = plain_word(tdcc_pkg::FUNC_SECONDS);
    w.set_sec = s;
    w.set_ns = ns;
    return w;
  endfunction

  function automatic clock_word_t random_word();
    clock_word_t w;
    int unsigned pick;
    logic [63:0] r;
    pick = $urandom_range(0, 99);
    w.func = pick < 45 ? tdcc_pkg::FUNC_TICK : pick < 65 ? tdcc_pkg::FUNC_DATE :
             pick < 85 ? tdcc_pkg::FUNC_SECONDS : tdcc_pkg::FUNC_READ;
    if ($urandom_range(0, 6) == 0) begin
      w.year = 14'($urandom);
      w.month = 4'($urandom);
      w.day = 5'($urandom);
      w.hour = 5'($urandom);
      w.minute = 6'($urandom);
      w.second = 6'($urandom);
    end else begin
      w.year = 14'($urandom_range(0, 9999));
      w.month = 4'($urandom_range(1, 12));
      w.day = 5'($urandom_range(1, 31));
      w.hour = 5'($urandom_range(0, 23));
      w.minute = 6'($urandom_range(0, 59));
      w.second = 6'($urandom_range(0, 60));
    end
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: w.set_sec = SEC_MAX - 40'($urandom_range(0, 3));
      1: w.set_sec = SEC_MIN + 40'($urandom_range(0, 3));
      2: w.set_sec = 40'(longint'($urandom_range(0, 200000)) - 100000);
      default: w.set_sec = r[39:0];
    endcase
    case ($urandom_range(0, 5))
      0: w.set_ns = 30'($urandom);
      1, 2: w.set_ns = tdcc_pkg::NS_MAX - 30'($urandom_range(0, 20000000));
      default: w.set_ns = 30'($urandom_range(0, 32'(tdcc_pkg::NS_MAX)));
    endcase
    return w;
  endfunction

  task automatic send_word(input clock_word_t w);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= w.func;
    year <= w.year;
    month <= w.month;
    day <= w.day;
    hour <= w.hour;
    minute <= w.minute;
    second <= w.second;
    set_sec <= w.set_sec;
    set_ns <= w.set_ns;
    do @(posedge clk); while (!in_ready_o);
    expected_readings.push_back(apply_word(w));
    word_count[w.func]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == STEP_ADDR) begin
      step_reg = data[tdcc_pkg::NS_W-1:0];
      step_settings++;
    end
    @(posedge clk);
  endtask

  task automatic check_step_register();
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= STEP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {2'b00, step_reg})
      report_mismatch("ns_per_tick readback", 64'(got), 64'(step_reg));
    @(posedge clk);
  endtask

  task automatic set_step(input logic [31:0] data);
    drain_results();
    apb_write(STEP_ADDR, data);
    check_step_register();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    clock_reading_t want;
    if (rst_n && out_valid_o && out_ready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(tick_total_o), '0);
      end else begin
        want = expected_readings.pop_front();
        if (tick_total_o !== want.ticks)
          report_mismatch("tick_total", 64'(tick_total_o), 64'(want.ticks));
        if (now_seconds_o !== want.now_s)
          report_mismatch("now_seconds", 64'($unsigned(now_seconds_o)),
                          64'(want.now_s));
        if (now_nanoseconds_o !== want.now_ns)
          report_mismatch("now_nanoseconds", 64'(now_nanoseconds_o), 64'(want.now_ns));
        if (uptime_seconds_o !== want.up_s)
          report_mismatch("uptime_seconds", 64'($unsigned(uptime_seconds_o)),
                          64'(want.up_s));
        if (uptime_nanoseconds_o !== want.up_ns)
          report_mismatch("uptime_nanoseconds", 64'(uptime_nanoseconds_o),
                          64'(want.up_ns));
      end
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_ready <= rst_n && (stall_left == 0);
  end

  task automatic test_reset_state();
    check_step_register();
    send_word(plain_word(tdcc_pkg::FUNC_READ));
    send_word(plain_word(tdcc_pkg::FUNC_TICK));
  endtask

  task automatic test_directed_words();
    idle_on = 1'b0;
    send_word(seconds_word(40'd0, tdcc_pkg::NS_MAX));
    send_word(plain_word(tdcc_pkg::FUNC_TICK));
    send_word(seconds_word(SEC_MAX, tdcc_pkg::NS_MAX));
    send_word(plain_word(tdcc_pkg::FUNC_TICK));
    send_word(seconds_word(SEC_MIN, 30'h3FFF_FFFF));
    send_word(seconds_word('1, tdcc_pkg::NS_PER_SEC));
    idle_on = 1'b1;
    send_word(date_word(1970, 1, 1, 0, 0, 0));
    send_word(date_word(0, 1, 1, 0, 0, 0));
    send_word(date_word(9999, 12, 31, 23, 59, 60));
    send_word(date_word(2000, 2, 29, 12, 30, 45));
    send_word(date_word(1900, 3, 1, 0, 0, 0));
    send_word(date_word(1969, 12, 31, 23, 59, 59));
    send_word(date_word(2024, 0, 15, 6, 7, 8));
    send_word(date_word(2024, 15, 31, 0, 0, 0));
    send_word(date_word(16383, 13, 0, 31, 63, 63));
    send_word(date_word(0, 0, 0, 0, 0, 0));
    send_word(plain_word(tdcc_pkg::FUNC_TICK));
    send_word(plain_word(tdcc_pkg::FUNC_READ));
  endtask

  task automatic test_tick_steps();
    logic [31:0] steps[6];
    steps = '{32'd0, 32'd1, {2'b00, tdcc_pkg::NS_MAX}, {2'b00, tdcc_pkg::NS_PER_SEC},
              32'hFFFF_FFFF, 32'hC000_0005};
    foreach (steps[i]) begin
      set_step(steps[i]);
      send_word(seconds_word(40'd100, tdcc_pkg::NS_MAX - 30'd5));
      repeat (3) send_word(plain_word(tdcc_pkg::FUNC_TICK));
      send_word(plain_word(tdcc_pkg::FUNC_READ));
    end
    // unmapped register must leave the step alone
    drain_results();
    apb_write(UNMAPPED_ADDR, 32'd12345);
    check_step_register();
    repeat (2) send_word(plain_word(tdcc_pkg::FUNC_TICK));
    set_step({2'b00, tdcc_pkg::NS_PER_TICK_RESET});
  endtask

  task automatic test_random_traffic();
    logic [31:0] steps[6];
    steps = '{{2'b00, tdcc_pkg::NS_PER_TICK_RESET}, 32'd1,
              32'($urandom_range(1, 32'(tdcc_pkg::NS_MAX))),
              {2'b00, tdcc_pkg::NS_MAX}, 32'hFFFF_FFFF, 32'd0};
    foreach (steps[i]) begin
      set_step(steps[i]);
      apb_write(UNMAPPED_ADDR, $urandom);
      for (int n = 0; n < 220; n++) begin
        idle_on = (n >= 40);
        send_word(random_word());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_words();
    test_tick_steps();
    test_random_traffic();
    drain_results();
    $display("covered %0d words: %0d ticks, %0d date loads, %0d seconds loads, %0d reads",
             word_count[tdcc_pkg::FUNC_TICK] + word_count[tdcc_pkg::FUNC_DATE]
             + word_count[tdcc_pkg::FUNC_SECONDS] + word_count[tdcc_pkg::FUNC_READ],
             word_count[tdcc_pkg::FUNC_TICK], word_count[tdcc_pkg::FUNC_DATE],
             word_count[tdcc_pkg::FUNC_SECONDS], word_count[tdcc_pkg::FUNC_READ]);
    $display("checked %0d results across %0d tick step settings, %0d mismatches",
             readings_seen, step_settings, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
